[hdl/shmc_pkg.sv]
// ----------------------------------------------------------------------------
// shmc_pkg
// Shared types, register indexes, phase and event codes for the stall homing
// motor controller.
// ----------------------------------------------------------------------------
package shmc_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned DUTY_W = 8;
  localparam int unsigned SMP_W  = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [DUTY_W-1:0] BRAKE_DUTY = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_DUTY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_THRESH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_CONFIRM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INRUSH         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_HOLD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_TIMEOUT = 3'd5;

  // command codes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_MOVE_A = 2'd1;
  localparam logic [1:0] MODE_MOVE_B = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // phase codes as reported
  localparam logic [1:0] PCODE_IDLE    = 2'd0;
  localparam logic [1:0] PCODE_MOVING  = 2'd1;
  localparam logic [1:0] PCODE_BRAKING = 2'd2;
  localparam logic [1:0] PCODE_ERROR   = 2'd3;

  // event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_STALL   = 3'd1;
  localparam logic [2:0] EV_ARRIVED = 3'd2;
  localparam logic [2:0] EV_TIMEOUT = 3'd3;
  localparam logic [2:0] EV_CLEARED = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_MOVING  = 4'b0010,
    PH_BRAKING = 4'b0100,
    PH_ERROR   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [DUTY_W-1:0] drive_duty;
    logic [SMP_W-1:0]  stall_level;
    logic [TICK_W-1:0] stall_confirm_ticks;
    logic [TICK_W-1:0] inrush_ticks;
    logic [TICK_W-1:0] brake_hold_ticks;
    logic [TICK_W-1:0] travel_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              bridge_in1;
    logic              bridge_in2;
    logic [DUTY_W-1:0] enable_duty;
    logic [1:0]        phase_code;
    logic              heading_a;
    logic [2:0]        event_code;
  } result_t;

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    sat_inc = (v == TICK_MAX) ? v : v + TICK_W'(1);
  endfunction

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] c;
    unique case (ph)
      PH_IDLE:    c = PCODE_IDLE;
      PH_MOVING:  c = PCODE_MOVING;
      PH_BRAKING: c = PCODE_BRAKING;
      PH_ERROR:   c = PCODE_ERROR;
      default:    c = PCODE_IDLE;
    endcase
    phase_code = c;
  endfunction

endpackage

[hdl/stall_homing_motor_controller.sv]
// ----------------------------------------------------------------------------
// stall_homing_motor_controller
// DC motor homing controller with stall detection, one tick per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is one millisecond tick carrying a command (mode) and a
//   current-sense sample. Each tick yields exactly one output beat with the
//   H-bridge drive levels, enable duty, phase, heading and event code.
//   The configuration port writes duty, timing and threshold registers by index;
//   write it only while no tick is in flight.
//   Path: a beat accepted into the input register passes through the
//   combinational state update and is then loaded into the result
//   register, from which it is presented on the output.
//   Throughput: one beat per cycle while the output is not stalled; the
//   state update between the input and result registers is combinational.
//   Reset (rst_n low, synchronous): phase idle, counters cleared, registers
//   back to defaults, both pipeline registers empty.
//   Output stall: the result register holds its beat while out_tready is
//   low; one more input beat is taken into the input register, then
//   in_tready drops until the output drains.
// ----------------------------------------------------------------------------
module stall_homing_motor_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [shmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [shmc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] mode, [13:2] current_sample, [15:14] zero
  input  logic [shmc_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] bridge_in1, [1] bridge_in2, [9:2] enable_duty, [11:10] phase_code,
  // [12] heading_a, [15:13] event_code
  output logic [shmc_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import shmc_pkg::*;

  cfg_t             cfg;
  result_t          res;
  logic             in_valid_r;
  logic [1:0]       mode_r;
  logic [SMP_W-1:0] sample_r;
  logic             out_valid_r;
  result_t          out_res_r;
  logic             advance;
  logic             step;

  shmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  shmc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .mode           (mode_r),
    .current_sample (sample_r),
    .cfg            (cfg),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r   <= in_tdata[1:0];
      sample_r <= in_tdata[SMP_W+1:2];
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.event_code, out_res_r.heading_a, out_res_r.phase_code,
                       out_res_r.enable_duty, out_res_r.bridge_in2, out_res_r.bridge_in1};

endmodule

[hdl/shmc_cfg.sv]
// ----------------------------------------------------------------------------
// shmc_cfg
// Configuration register file with reset defaults, written by index.
// ----------------------------------------------------------------------------
module shmc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [shmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [shmc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output shmc_pkg::cfg_t                     cfg
);
  import shmc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DRIVE_DUTY:     cfg_nxt.drive_duty = cfg_wdata[DUTY_W-1:0];
        REG_STALL_THRESH:   cfg_nxt.stall_level = cfg_wdata[SMP_W-1:0];
        REG_STALL_CONFIRM:  cfg_nxt.stall_confirm_ticks = cfg_wdata[TICK_W-1:0];
        REG_INRUSH:         cfg_nxt.inrush_ticks = cfg_wdata[TICK_W-1:0];
        REG_BRAKE_HOLD:     cfg_nxt.brake_hold_ticks = cfg_wdata[TICK_W-1:0];
        REG_TRAVEL_TIMEOUT: cfg_nxt.travel_timeout_ticks = cfg_wdata[TICK_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_duty           <= DUTY_W'(180);
      cfg_r.stall_level          <= SMP_W'(600);
      cfg_r.stall_confirm_ticks  <= TICK_W'(50);
      cfg_r.inrush_ticks         <= TICK_W'(200);
      cfg_r.brake_hold_ticks     <= TICK_W'(250);
      cfg_r.travel_timeout_ticks <= TICK_W'(5000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/shmc_core.sv]
// ----------------------------------------------------------------------------
// shmc_core
// Motor phase state, tick counters and one-tick update with result decode.
// ----------------------------------------------------------------------------
module shmc_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [1:0]                     mode,
  input  logic [shmc_pkg::SMP_W-1:0]     current_sample,
  input  shmc_pkg::cfg_t                 cfg,
  output shmc_pkg::result_t              res
);
  import shmc_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic              toward_a_r, toward_a_nxt;
  logic [TICK_W-1:0] travel_cnt_r, travel_cnt_nxt;
  logic              stall_armed_r, stall_armed_nxt;
  logic              stall_pending_r, stall_pending_nxt;
  logic [TICK_W-1:0] stall_cnt_r, stall_cnt_nxt;
  logic [TICK_W-1:0] brake_cnt_r, brake_cnt_nxt;
  logic [2:0]        event_code;

  always_comb begin
    phase_nxt         = phase_r;
    toward_a_nxt      = toward_a_r;
    travel_cnt_nxt    = travel_cnt_r;
    stall_armed_nxt   = stall_armed_r;
    stall_pending_nxt = stall_pending_r;
    stall_cnt_nxt     = stall_cnt_r;
    brake_cnt_nxt     = brake_cnt_r;
    event_code        = EV_NONE;

    // tick update
    unique case (phase_r)
      PH_MOVING: begin
        travel_cnt_nxt = sat_inc(travel_cnt_r);
        if (travel_cnt_nxt >= cfg.travel_timeout_ticks) begin
          phase_nxt  = PH_ERROR;
          event_code = EV_TIMEOUT;
        end else begin
          if (!stall_armed_r && travel_cnt_nxt >= cfg.inrush_ticks) begin
            stall_armed_nxt = 1'b1;
          end
          if (stall_armed_nxt) begin
            if (current_sample >= cfg.stall_level) begin
              if (!stall_pending_r) begin
                stall_pending_nxt = 1'b1;
                stall_cnt_nxt     = '0;
              end else begin
                stall_cnt_nxt = sat_inc(stall_cnt_r);
                if (stall_cnt_nxt >= cfg.stall_confirm_ticks) begin
                  phase_nxt     = PH_BRAKING;
                  brake_cnt_nxt = '0;
                  event_code    = EV_STALL;
                end
              end
            end else begin
              stall_pending_nxt = 1'b0;
            end
          end
        end
      end
      PH_BRAKING: begin
        brake_cnt_nxt = sat_inc(brake_cnt_r);
        if (brake_cnt_nxt >= cfg.brake_hold_ticks) begin
          phase_nxt  = PH_IDLE;
          event_code = EV_ARRIVED;
        end
      end
      default: begin
      end
    endcase

    // command
    unique case (mode)
      MODE_MOVE_A, MODE_MOVE_B: begin
        if (phase_nxt != PH_BRAKING) begin
          toward_a_nxt      = (mode == MODE_MOVE_A);
          phase_nxt         = PH_MOVING;
          travel_cnt_nxt    = '0;
          stall_armed_nxt   = 1'b0;
          stall_pending_nxt = 1'b0;
          stall_cnt_nxt     = '0;
        end
      end
      MODE_CLEAR: begin
        if (phase_nxt == PH_ERROR) begin
          phase_nxt  = PH_IDLE;
          event_code = EV_CLEARED;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.phase_code = phase_code(phase_nxt);
    res.heading_a  = toward_a_nxt;
    res.event_code = event_code;
    unique case (phase_nxt)
      PH_MOVING: begin
        res.bridge_in1  = toward_a_nxt;
        res.bridge_in2  = !toward_a_nxt;
        res.enable_duty = cfg.drive_duty;
      end
      PH_BRAKING: begin
        res.bridge_in1  = 1'b1;
        res.bridge_in2  = 1'b1;
        res.enable_duty = BRAKE_DUTY;
      end
      default: begin
        res.bridge_in1  = 1'b0;
        res.bridge_in2  = 1'b0;
        res.enable_duty = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      toward_a_r      <= 1'b0;
      travel_cnt_r    <= '0;
      stall_armed_r   <= 1'b0;
      stall_pending_r <= 1'b0;
      stall_cnt_r     <= '0;
      brake_cnt_r     <= '0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      toward_a_r      <= toward_a_nxt;
      travel_cnt_r    <= travel_cnt_nxt;
      stall_armed_r   <= stall_armed_nxt;
      stall_pending_r <= stall_pending_nxt;
      stall_cnt_r     <= stall_cnt_nxt;
      brake_cnt_r     <= brake_cnt_nxt;
    end
  end

  a_stall_brakes: assert property (@(posedge clk) disable iff (!rst_n)
    step && event_code == EV_STALL |-> phase_nxt == PH_BRAKING)
    else $error("stall event without braking");

  a_clear_idles: assert property (@(posedge clk) disable iff (!rst_n)
    step && event_code == EV_CLEARED |=> phase_r == PH_IDLE)
    else $error("error clear did not return to idle");

  a_brake_armed: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BRAKING |-> stall_armed_r)
    else $error("braking without armed stall check");

endmodule
